// ----- hdl/bitmap_slot_pool_allocator_unit_defines.svh -----
// assertion macros shared by the allocator checker
`ifndef BITMAP_SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_SLOT_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, skipped while reset is high
`define BSPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("allocator check failed");

// next-cycle implication, skipped while reset is high
`define BSPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("allocator check failed");

`endif

// ----- hdl/bspa_pkg.sv -----
// shared types, widths and codes of the slot pool allocator
package bspa_pkg;

   // build-time slot count and the hard map limit
   localparam int MAX_SLOTS_DEFAULT = 64;
   localparam int MAP_LIMIT         = 64;

   // priority search groups
   localparam int GROUP_SIZE = 8;
   localparam int SUB_W      = 3;

   // field widths
   localparam int REQ_TYPE_W = 3;
   localparam int SLOT_W     = 6;
   localparam int GRP_W      = SLOT_W - SUB_W;
   localparam int COUNT_W    = 7;
   localparam int STRIDE_W   = 16;
   localparam int OFFSET_W   = 22;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // request codes
   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_ALLOC    = 3'd0,
      OP_FREE     = 3'd1,
      OP_FREE_ALL = 3'd2,
      OP_FIRST    = 3'd3,
      OP_NEXT     = 3'd4
   } op_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_STRIDE   = 1'd1;

   // register reset values
   localparam logic [COUNT_W-1:0]  CAPACITY_RESET = 7'd64;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET   = 16'd1;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic find;
      logic emit;
   } cmd_type;

endpackage

// ----- hdl/bspa_ctrl.sv -----
// controller state machine: sequences load, find and emit of one item
module bspa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output bspa_pkg::cmd_type cmd
);
   import bspa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      find_ff, find_in;
   logic      emit_ff, emit_in;
   logic      accept;

   // item accepted only from idle
   assign accept = start && (state_ff == ST_IDLE);

   // next state and registered commands
   always_comb begin
      state_in = state_ff;
      busy_in  = 1'b0;
      find_in  = 1'b0;
      emit_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FIND;
               busy_in  = 1'b1;
               find_in  = 1'b1;
            end
         end
         ST_FIND: begin
            state_in = ST_EMIT;
            busy_in  = 1'b1;
            emit_in  = 1'b1;
         end
         ST_EMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         find_ff  <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         find_ff  <= find_in;
         emit_ff  <= emit_in;
      end
   end

   assign busy     = busy_ff;
   assign cmd.load = accept;
   assign cmd.find = find_ff;
   assign cmd.emit = emit_ff;

endmodule

// ----- hdl/bspa_datapath.sv -----
// datapath: liveness map, live count, registered priority search and offset
module bspa_datapath #(
   parameter int MAX_SLOTS = bspa_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bspa_pkg::cmd_type               cmd,
   input  logic [bspa_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic [bspa_pkg::SLOT_W-1:0]     req_slot_in,
   input  logic                            csr_write_enable,
   input  logic [bspa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bspa_pkg::CSR_DATA_W-1:0] csr_write_data,
   output logic                            rsp_strobe,
   output logic                            rsp_ok,
   output logic [bspa_pkg::SLOT_W-1:0]     rsp_slot_out,
   output logic [bspa_pkg::OFFSET_W-1:0]   rsp_byte_offset,
   output logic [bspa_pkg::COUNT_W-1:0]    rsp_live_count,
   output logic                            rsp_is_full
);
   import bspa_pkg::*;

   localparam int MapDepth  = (MAX_SLOTS < MAP_LIMIT) ? MAX_SLOTS : MAP_LIMIT;
   localparam int NumGroups = (MapDepth + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PadW      = NumGroups * GROUP_SIZE;

   // architectural state
   logic [MapDepth-1:0]   map_ff, map_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    capacity_ff;
   logic [STRIDE_W-1:0]   stride_ff;

   // search stage registers
   logic [REQ_TYPE_W-1:0] op_ff;
   logic [SLOT_W-1:0]     slot_in_ff;
   logic                  free_hit_ff;
   logic [NumGroups-1:0]  grp_hit_ff, grp_hit_in;
   logic [SUB_W-1:0]      grp_sub_ff [NumGroups];
   logic [SUB_W-1:0]      grp_sub_in [NumGroups];

   // find stage registers
   logic                  res_ok_ff, res_ok_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;

   // output registers
   logic                  rsp_strobe_ff;
   logic                  rsp_ok_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [OFFSET_W-1:0]   rsp_offset_ff, offset_in;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic                  rsp_full_ff;

   logic [COUNT_W-1:0]    cap_eff;
   logic [COUNT_W-1:0]    start_pos;
   logic                  room;
   logic [MAP_LIMIT-1:0]  map_ext, map_ext_in;
   logic [PadW-1:0]       cand;
   logic                  found;
   logic [GRP_W-1:0]      sel_grp;
   logic [SUB_W-1:0]      sel_sub;
   logic [SLOT_W-1:0]     sel_idx;

   // effective capacity, clipped to the built map
   assign cap_eff = (capacity_ff > COUNT_W'(MapDepth)) ? COUNT_W'(MapDepth) : capacity_ff;
   assign room    = count_ff < cap_eff;
   assign map_ext = MAP_LIMIT'(map_ff);

   // search start: zero for first, one past the slot for next
   assign start_pos = (req_type == OP_NEXT) ? (COUNT_W'(req_slot_in) + COUNT_W'(1))
                                            : '0;

   // candidate vector for the requested search
   always_comb begin
      cand = '0;
      for (int i = 0; i < MapDepth; i++) begin
         case (req_type)
            OP_ALLOC: begin
               cand[i] = !map_ff[i] && (COUNT_W'(i) < cap_eff) && room;
            end
            OP_FIRST, OP_NEXT: begin
               cand[i] = map_ff[i] && (COUNT_W'(i) < cap_eff) && (COUNT_W'(i) >= start_pos);
            end
            default: begin
               cand[i] = 1'b0;
            end
         endcase
      end
   end

   // first search level: hit and lowest position inside each group
   always_comb begin
      for (int g = 0; g < NumGroups; g++) begin
         grp_hit_in[g] = |cand[g*GROUP_SIZE +: GROUP_SIZE];
         grp_sub_in[g] = '0;
         for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            if (cand[g*GROUP_SIZE + j]) begin
               grp_sub_in[g] = SUB_W'(j);
            end
         end
      end
   end

   // capture item and first search level
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_type;
         slot_in_ff  <= req_slot_in;
         free_hit_ff <= (COUNT_W'(req_slot_in) < cap_eff) && map_ext[req_slot_in];
         grp_hit_ff  <= grp_hit_in;
         grp_sub_ff  <= grp_sub_in;
      end
   end

   // second search level: lowest group with a hit
   always_comb begin
      found   = |grp_hit_ff;
      sel_grp = '0;
      sel_sub = '0;
      for (int g = NumGroups - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            sel_grp = GRP_W'(g);
            sel_sub = grp_sub_ff[g];
         end
      end
      sel_idx = {sel_grp, sel_sub};
   end

   // apply the request to map and count
   always_comb begin
      map_ext_in  = map_ext;
      count_in    = count_ff;
      res_ok_in   = 1'b0;
      res_slot_in = '0;
      case (op_ff)
         OP_ALLOC: begin
            if (found) begin
               map_ext_in[sel_idx] = 1'b1;
               count_in            = count_ff + COUNT_W'(1);
               res_ok_in           = 1'b1;
               res_slot_in         = sel_idx;
            end
         end
         OP_FREE: begin
            if (free_hit_ff) begin
               map_ext_in[slot_in_ff] = 1'b0;
               if (count_ff != '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end
               res_ok_in   = 1'b1;
               res_slot_in = slot_in_ff;
            end
         end
         OP_FREE_ALL: begin
            map_ext_in = '0;
            count_in   = '0;
            res_ok_in  = 1'b1;
         end
         OP_FIRST, OP_NEXT: begin
            if (found) begin
               res_ok_in   = 1'b1;
               res_slot_in = sel_idx;
            end
         end
         default: begin
            res_ok_in = 1'b0;
         end
      endcase
      map_in = MapDepth'(map_ext_in);
   end

   // map, count and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff      <= '0;
         count_ff    <= '0;
         capacity_ff <= CAPACITY_RESET;
         stride_ff   <= STRIDE_RESET;
      end else begin
         if (cmd.find) begin
            map_ff   <= map_in;
            count_ff <= count_in;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_POOL_CAPACITY: capacity_ff <= csr_write_data[COUNT_W-1:0];
               CSR_SLOT_STRIDE:   stride_ff   <= csr_write_data[STRIDE_W-1:0];
               default:           capacity_ff <= capacity_ff;
            endcase
         end
      end
   end

   // find stage result
   always_ff @(posedge clock) begin
      if (cmd.find) begin
         res_ok_ff   <= res_ok_in;
         res_slot_ff <= res_slot_in;
      end
   end

   // byte offset; slot is zero when nothing was found
   assign offset_in = OFFSET_W'(res_slot_ff) * OFFSET_W'(stride_ff);

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_ok_ff     <= res_ok_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_offset_ff <= offset_in;
         rsp_count_ff  <= count_ff;
         rsp_full_ff   <= count_ff >= cap_eff;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_byte_offset = rsp_offset_ff;
   assign rsp_live_count  = rsp_count_ff;
   assign rsp_is_full     = rsp_full_ff;

endmodule

// ----- hdl/bitmap_slot_pool_allocator_unit.sv -----
// top level of the bitmap slot pool allocator
// An item (allocate, free, free all, first live, next live) is taken when start is high
// and busy is low; busy then stays high and the result appears on the rsp_ ports for one
// cycle with rsp_strobe. The block takes no new item until that result is shown, and it
// handles each item in order: the per-group priority search, then the cross-group pick
// and map update, then the registered slot-times-stride multiply. The receiver cannot
// stall: the result must be taken in its strobe cycle. Slot map and live count clear at
// reset. Write registers through the csr_ port only while idle; the block does not check.
module bitmap_slot_pool_allocator_unit #(
   parameter int MAX_SLOTS = bspa_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bspa_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic [bspa_pkg::SLOT_W-1:0]     req_slot_in,
   input  logic                            csr_write_enable,
   input  logic [bspa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bspa_pkg::CSR_DATA_W-1:0] csr_write_data,
   output logic                            rsp_strobe,
   output logic                            rsp_ok,
   output logic [bspa_pkg::SLOT_W-1:0]     rsp_slot_out,
   output logic [bspa_pkg::OFFSET_W-1:0]   rsp_byte_offset,
   output logic [bspa_pkg::COUNT_W-1:0]    rsp_live_count,
   output logic                            rsp_is_full
);
   import bspa_pkg::*;

   cmd_type cmd;

   // sequencer
   bspa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // map, search and result path
   bspa_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_type         (req_type),
      .req_slot_in      (req_slot_in),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_ok           (rsp_ok),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_live_count   (rsp_live_count),
      .rsp_is_full      (rsp_is_full)
   );

endmodule

// ----- hdl/bspa_checker.sv -----
// port-level checker for the allocator, bound to the top level
`include "bitmap_slot_pool_allocator_unit_defines.svh"

module bspa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_strobe,
   input logic                            rsp_ok,
   input logic [bspa_pkg::SLOT_W-1:0]     rsp_slot_out,
   input logic [bspa_pkg::OFFSET_W-1:0]   rsp_byte_offset
);

   // every accepted item is followed by its result strobe
   `BSPA_ASSERT_NOW(a_item_result, clock, reset, start && !busy, ##3 rsp_strobe)

   // a result strobe lasts a single cycle
   `BSPA_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)

   // the block is ready again while its result is shown
   `BSPA_ASSERT_NOW(a_ready_on_result, clock, reset, rsp_strobe, !busy)

   // a failed request reports slot and offset zero
   `BSPA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_strobe && !rsp_ok,
      (rsp_slot_out == '0) && (rsp_byte_offset == '0))

endmodule

bind bitmap_slot_pool_allocator_unit bspa_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_ok          (rsp_ok),
   .rsp_slot_out    (rsp_slot_out),
   .rsp_byte_offset (rsp_byte_offset)
);
